/* sv/esa_pkg.sv */
`timescale 1ns / 1ps

package esa_pkg;

	localparam int MAX_SLOTS   = 40;
	localparam int TABLE_DEPTH = MAX_SLOTS + 1;
	localparam int SLOT_W      = 7;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(2);
	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(MAX_SLOTS);

	localparam logic [2:0] KIND_ALLOC    = 3'd0;
	localparam logic [2:0] KIND_FREE     = 3'd1;
	localparam logic [2:0] KIND_FREE_ALL = 3'd2;
	localparam logic [2:0] KIND_START    = 3'd3;
	localparam logic [2:0] KIND_STOP     = 3'd4;
	localparam logic [2:0] KIND_STOP_ALL = 3'd5;
	localparam logic [2:0] KIND_SET_EN   = 3'd6;

	localparam logic [1:0] STATUS_DONE   = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_BAD_ID = 2'd2;

	localparam logic [1:0] FLAG_ALLOC = 2'b01;
	localparam logic [1:0] FLAG_PLAY  = 2'b10;

	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LATCH    = 4'd1;
	localparam logic [3:0] OP_GRANT    = 4'd2;
	localparam logic [3:0] OP_RD       = 4'd3;
	localparam logic [3:0] OP_SCAN_END = 4'd4;
	localparam logic [3:0] OP_INC      = 4'd5;
	localparam logic [3:0] OP_NAMED    = 4'd6;
	localparam logic [3:0] OP_CLR      = 4'd7;
	localparam logic [3:0] OP_STOP_ONE = 4'd8;
	localparam logic [3:0] OP_RES_FULL = 4'd9;
	localparam logic [3:0] OP_RES_BAD  = 4'd10;
	localparam logic [3:0] OP_PUBLISH  = 4'd11;

	typedef struct packed {
		logic [2:0]        kind;
		logic [SLOT_W-1:0] slot_id;
		logic              enable;
	} req_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0] new_slot;
		logic [1:0]        status;
		logic [1:0]        slot_flags;
		logic              notify_device;
	} rsp_word_t;

	typedef struct packed {
		logic [3:0] op;
		logic       clr_dis;
	} esa_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       id_ok;
		logic       full;
		logic       scan_end;
		logic       at_last;
		logic       slot_free;
		logic       out_busy;
	} esa_stat_t;

endpackage

/* sv/esa_dp.sv */
`timescale 1ns / 1ps

module esa_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  esa_pkg::req_word_t req,
	input  esa_pkg::esa_cmd_t  cmd,
	output esa_pkg::esa_stat_t stat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output esa_pkg::rsp_word_t rsp
);

	logic [1:0] flag_mem [esa_pkg::TABLE_DEPTH];
	logic       dis_mem  [esa_pkg::TABLE_DEPTH];

	logic [2:0]                 kind_q;
	logic [esa_pkg::SLOT_W-1:0] id_q;
	logic                       enable_q;
	logic [esa_pkg::SLOT_W-1:0] ptr_q;
	logic [esa_pkg::SLOT_W-1:0] next_free_q;
	logic [1:0]                 rd_flags_q;
	logic                       rd_dis_q;
	esa_pkg::rsp_word_t         res_q;
	esa_pkg::rsp_word_t         rsp_q;
	logic                       rsp_valid_q;

	logic [esa_pkg::IDX_W-1:0]  addr;
	logic [1:0]                 named_flags;
	logic                       named_notify;
	logic [esa_pkg::SLOT_W-1:0] ptr_start;

	assign addr = ptr_q[esa_pkg::IDX_W-1:0];

	always_comb begin
		named_flags  = rd_flags_q;
		named_notify = 1'b0;
		unique case (kind_q)
			esa_pkg::KIND_FREE: begin
				named_flags = 2'b00;
			end
			esa_pkg::KIND_START: begin
				named_flags = rd_flags_q | esa_pkg::FLAG_PLAY;
			end
			esa_pkg::KIND_STOP: begin
				named_flags  = rd_flags_q & ~esa_pkg::FLAG_PLAY;
				named_notify = ~rd_dis_q;
			end
			esa_pkg::KIND_SET_EN: begin
				if (rd_flags_q[1]) begin
					named_flags  = rd_flags_q & ~esa_pkg::FLAG_PLAY;
					named_notify = enable_q;
				end
			end
			default: begin
				named_flags = rd_flags_q;
			end
		endcase
	end

	always_comb begin
		unique case (req.kind)
			esa_pkg::KIND_ALLOC: ptr_start = next_free_q + esa_pkg::SLOT_W'(1);
			esa_pkg::KIND_FREE,
			esa_pkg::KIND_START,
			esa_pkg::KIND_STOP,
			esa_pkg::KIND_SET_EN: ptr_start = req.slot_id;
			default: ptr_start = esa_pkg::FIRST_SLOT;
		endcase
	end

	assign stat.kind      = kind_q;
	assign stat.id_ok     = (id_q >= esa_pkg::FIRST_SLOT) && (id_q <= esa_pkg::LAST_SLOT);
	assign stat.full      = next_free_q >= esa_pkg::LAST_SLOT;
	assign stat.scan_end  = ptr_q >= esa_pkg::LAST_SLOT;
	assign stat.at_last   = ptr_q == esa_pkg::LAST_SLOT;
	assign stat.slot_free = rd_flags_q == 2'b00;
	assign stat.out_busy  = rsp_valid_q & rsp_stall;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			esa_pkg::OP_GRANT: begin
				flag_mem[next_free_q[esa_pkg::IDX_W-1:0]] <= esa_pkg::FLAG_ALLOC;
			end
			esa_pkg::OP_RD: begin
				rd_flags_q <= flag_mem[addr];
				rd_dis_q   <= dis_mem[addr];
			end
			esa_pkg::OP_NAMED: begin
				flag_mem[addr] <= named_flags;
				if (kind_q == esa_pkg::KIND_SET_EN) begin
					dis_mem[addr] <= ~enable_q;
				end
			end
			esa_pkg::OP_CLR: begin
				flag_mem[addr] <= 2'b00;
				if (cmd.clr_dis) begin
					dis_mem[addr] <= 1'b0;
				end
			end
			esa_pkg::OP_STOP_ONE: begin
				flag_mem[addr] <= rd_flags_q & ~esa_pkg::FLAG_PLAY;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			esa_pkg::OP_LATCH: begin
				kind_q   <= req.kind;
				id_q     <= req.slot_id;
				enable_q <= req.enable;
				res_q    <= '0;
			end
			esa_pkg::OP_GRANT: begin
				res_q.new_slot   <= next_free_q;
				res_q.slot_flags <= esa_pkg::FLAG_ALLOC;
			end
			esa_pkg::OP_NAMED: begin
				res_q.slot_flags    <= named_flags;
				res_q.notify_device <= named_notify;
			end
			esa_pkg::OP_STOP_ONE: begin
				res_q.notify_device <= res_q.notify_device | ~rd_dis_q;
			end
			esa_pkg::OP_RES_FULL: begin
				res_q.status <= esa_pkg::STATUS_FULL;
			end
			esa_pkg::OP_RES_BAD: begin
				res_q.status <= esa_pkg::STATUS_BAD_ID;
			end
			esa_pkg::OP_PUBLISH: begin
				rsp_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= esa_pkg::FIRST_SLOT;
			next_free_q <= esa_pkg::FIRST_SLOT;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				esa_pkg::OP_LATCH: begin
					ptr_q <= ptr_start;
				end
				esa_pkg::OP_SCAN_END: begin
					next_free_q <= ptr_q;
				end
				esa_pkg::OP_INC,
				esa_pkg::OP_STOP_ONE: begin
					ptr_q <= ptr_q + esa_pkg::SLOT_W'(1);
				end
				esa_pkg::OP_CLR: begin
					ptr_q       <= ptr_q + esa_pkg::SLOT_W'(1);
					next_free_q <= esa_pkg::FIRST_SLOT;
				end
				esa_pkg::OP_NAMED: begin
					if (kind_q == esa_pkg::KIND_FREE && id_q < next_free_q) begin
						next_free_q <= id_q;
					end
				end
				default: begin
				end
			endcase

			if (cmd.op == esa_pkg::OP_PUBLISH) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* sv/esa_ctrl.sv */
`timescale 1ns / 1ps

module esa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  esa_pkg::esa_stat_t stat,
	output esa_pkg::esa_cmd_t  cmd
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DISPATCH = 4'd2;
	localparam logic [3:0] S_SCAN_RD  = 4'd3;
	localparam logic [3:0] S_SCAN_CHK = 4'd4;
	localparam logic [3:0] S_NAMED_RD = 4'd5;
	localparam logic [3:0] S_NAMED_EX = 4'd6;
	localparam logic [3:0] S_FREE_ALL = 4'd7;
	localparam logic [3:0] S_SA_RD    = 4'd8;
	localparam logic [3:0] S_SA_WR    = 4'd9;
	localparam logic [3:0] S_DONE     = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d     = state_q;
		cmd.op      = esa_pkg::OP_NONE;
		cmd.clr_dis = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op      = esa_pkg::OP_CLR;
				cmd.clr_dis = 1'b1;
				if (stat.at_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = esa_pkg::OP_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.kind)
					esa_pkg::KIND_ALLOC: begin
						if (stat.full) begin
							cmd.op  = esa_pkg::OP_RES_FULL;
							state_d = S_DONE;
						end else begin
							cmd.op  = esa_pkg::OP_GRANT;
							state_d = S_SCAN_RD;
						end
					end
					esa_pkg::KIND_FREE_ALL: begin
						state_d = S_FREE_ALL;
					end
					esa_pkg::KIND_STOP_ALL: begin
						state_d = S_SA_RD;
					end
					esa_pkg::KIND_FREE,
					esa_pkg::KIND_START,
					esa_pkg::KIND_STOP,
					esa_pkg::KIND_SET_EN: begin
						if (stat.id_ok) begin
							state_d = S_NAMED_RD;
						end else begin
							cmd.op  = esa_pkg::OP_RES_BAD;
							state_d = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (stat.scan_end) begin
					cmd.op  = esa_pkg::OP_SCAN_END;
					state_d = S_DONE;
				end else begin
					cmd.op  = esa_pkg::OP_RD;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (stat.slot_free) begin
					cmd.op  = esa_pkg::OP_SCAN_END;
					state_d = S_DONE;
				end else begin
					cmd.op  = esa_pkg::OP_INC;
					state_d = S_SCAN_RD;
				end
			end
			S_NAMED_RD: begin
				cmd.op  = esa_pkg::OP_RD;
				state_d = S_NAMED_EX;
			end
			S_NAMED_EX: begin
				cmd.op  = esa_pkg::OP_NAMED;
				state_d = S_DONE;
			end
			S_FREE_ALL: begin
				cmd.op = esa_pkg::OP_CLR;
				if (stat.at_last) begin
					state_d = S_DONE;
				end
			end
			S_SA_RD: begin
				cmd.op  = esa_pkg::OP_RD;
				state_d = S_SA_WR;
			end
			S_SA_WR: begin
				cmd.op = esa_pkg::OP_STOP_ONE;
				state_d = stat.at_last ? S_DONE : S_SA_RD;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.op  = esa_pkg::OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = state_q != S_IDLE;

endmodule

/* sv/effect_slot_allocator_core.sv */
`timescale 1ns / 1ps
// One word is taken at a time; the next is accepted once the current result is registered.
// Named commands read their slot and write it back; free-all and stop-all sweep every slot.
// Allocate on a full table reports full; otherwise it grants the next free slot and scans forward
// from it past occupied slots until it finds a free one or reaches LAST_SLOT.
// The slot table is single-port, so a sweep that updates entries reads and writes each in separate states.
// After reset a clearing pass zeroes slots FIRST_SLOT to LAST_SLOT before the first word is taken.

module effect_slot_allocator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  esa_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output esa_pkg::rsp_word_t rsp
);

	esa_pkg::esa_cmd_t  cmd;
	esa_pkg::esa_stat_t stat;

	esa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	esa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

/* dv/effect_slot_allocator_core_tb.sv */
`timescale 1ns / 1ps

module effect_slot_allocator_core_tb;
	import esa_pkg::*;

	localparam logic [2:0] KIND_UNKNOWN = 3'd7;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 4 * MAX_SLOTS;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_WORDS = 850;

	class slot_reply_tracker;
		logic [1:0]        slot_state [TABLE_DEPTH];
		bit                disabled   [TABLE_DEPTH];
		logic [SLOT_W-1:0] next_free;
		rsp_word_t         expected_replies [$];
		int                errors;

		function new();
			foreach (slot_state[i]) begin
				slot_state[i] = 2'b00;
				disabled[i]   = 1'b0;
			end
			next_free = FIRST_SLOT;
			errors    = 0;
		endfunction

		function void predict_reply(req_word_t w);
			rsp_word_t r;
			int        p;
			r = '0;
			case (w.kind)
			KIND_ALLOC: begin
				if (next_free >= LAST_SLOT) begin
					r.status = STATUS_FULL;
				end else begin
					r.new_slot = next_free;
					p = int'(next_free) + 1;
					while (p < MAX_SLOTS && slot_state[p] != 2'b00)
						p++;
					next_free = SLOT_W'(p);
					slot_state[r.new_slot] = FLAG_ALLOC;
					r.slot_flags = FLAG_ALLOC;
				end
			end
			KIND_FREE_ALL: begin
				foreach (slot_state[i])
					slot_state[i] = 2'b00;
				next_free = FIRST_SLOT;
			end
			KIND_STOP_ALL: begin
				for (int s = FIRST_SLOT; s <= MAX_SLOTS; s++) begin
					slot_state[s] = slot_state[s] & ~FLAG_PLAY;
					if (!disabled[s])
						r.notify_device = 1'b1;
				end
			end
			KIND_FREE, KIND_START, KIND_STOP, KIND_SET_EN: begin
				if (w.slot_id < FIRST_SLOT || w.slot_id > LAST_SLOT) begin
					r.status = STATUS_BAD_ID;
				end else begin
					if (w.kind == KIND_FREE) begin
						slot_state[w.slot_id] = 2'b00;
						if (w.slot_id < next_free)
							next_free = w.slot_id;
					end else if (w.kind == KIND_START) begin
						slot_state[w.slot_id] = slot_state[w.slot_id] | FLAG_PLAY;
					end else if (w.kind == KIND_STOP) begin
						slot_state[w.slot_id] = slot_state[w.slot_id] & ~FLAG_PLAY;
						r.notify_device = !disabled[w.slot_id];
					end else begin
						disabled[w.slot_id] = !w.enable;
						if ((slot_state[w.slot_id] & FLAG_PLAY) != 2'b00) begin
							slot_state[w.slot_id] = slot_state[w.slot_id] & ~FLAG_PLAY;
							r.notify_device = !disabled[w.slot_id];
						end
					end
					r.slot_flags = slot_state[w.slot_id];
				end
			end
			default: begin
				r = '0;
			end
			endcase
			expected_replies.push_back(r);
		endfunction

		function void check_reply(rsp_word_t got);
			rsp_word_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: reply %h arrived with none expected", $time, got);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.new_slot !== want.new_slot) begin
				$display("%0t: new_slot expected %0d, got %0d", $time, want.new_slot, got.new_slot);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.slot_flags !== want.slot_flags) begin
				$display("%0t: slot_flags expected %b, got %b", $time, want.slot_flags,
					got.slot_flags);
				errors++;
			end
			if (got.notify_device !== want.notify_device) begin
				$display("%0t: notify_device expected %b, got %b", $time, want.notify_device,
					got.notify_device);
				errors++;
			end
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	slot_reply_tracker replies = new();

	int idle_pct         = 0;
	int stall_pct        = 0;
	bit hold_off_request = 1'b0;
	int hold_left        = 0;
	int words_sent       = 0;
	int cycle_count      = 0;

	effect_slot_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL effect_slot_allocator_core");
			$finish;
		end
	end

	// The long hold-off is counted here so that the sender keeps offering words meanwhile.
	always @(posedge clk) begin
		if (hold_off_request) begin
			hold_off_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			replies.check_reply(rsp);
	end

	task automatic send_word(input logic [2:0] kind, input int id, input bit en);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{kind: kind, slot_id: SLOT_W'(id), enable: en};
		do
			@(posedge clk);
		while (req_stall);
		replies.predict_reply(req);
		words_sent++;
	endtask

	task automatic pause_until_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (replies.expected_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_slot();
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return $urandom_range(MAX_SLOTS, FIRST_SLOT);
		if (r < 93)
			return (r < 89) ? $urandom_range(1) : MAX_SLOTS + 1;
		return $urandom_range(127);
	endfunction

	task automatic run_random_episode();
		int pick;
		int k;
		bit sweep_en;
		pick = $urandom_range(99);
		if (pick < 30) begin
			repeat ($urandom_range(MAX_SLOTS + 4, 3))
				send_word(KIND_ALLOC, $urandom_range(127), 1'($urandom_range(1)));
		end else if (pick < 45) begin
			repeat ($urandom_range(12, 2))
				send_word(KIND_FREE, pick_slot(), 1'($urandom_range(1)));
		end else if (pick < 70) begin
			repeat ($urandom_range(16, 4)) begin
				k = $urandom_range(2);
				send_word((k == 0) ? KIND_START : (k == 1) ? KIND_STOP : KIND_SET_EN,
					pick_slot(), $urandom_range(99) < 70);
			end
		end else if (pick < 80) begin
			repeat ($urandom_range(8, 2))
				send_word(3'($urandom_range(7)), $urandom_range(127),
					1'($urandom_range(1)));
		end else if (pick < 88) begin
			send_word(KIND_STOP_ALL, $urandom_range(127), 1'($urandom_range(1)));
		end else if (pick < 93) begin
			send_word(KIND_FREE_ALL, $urandom_range(127), 1'($urandom_range(1)));
		end else begin
			// Marking every slot the same way lets stop-all report no device stop at all.
			sweep_en = 1'($urandom_range(1));
			for (int s = FIRST_SLOT; s <= MAX_SLOTS; s++)
				send_word(KIND_SET_EN, s, sweep_en);
			send_word(KIND_STOP_ALL, 0, 1'b0);
		end
	endtask

	int idle_plan  [4] = '{0, 62, 0, 18};
	int stall_plan [4] = '{0, 0, 62, 18};

	initial begin
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(KIND_UNKNOWN, 127, 1'b1);
		send_word(KIND_ALLOC, 0, 1'b0);
		send_word(KIND_ALLOC, 0, 1'b0);
		send_word(KIND_START, 5, 1'b0);
		send_word(KIND_ALLOC, 127, 1'b1);
		send_word(KIND_ALLOC, 0, 1'b0);
		send_word(KIND_START, 3, 1'b0);
		send_word(KIND_SET_EN, 3, 1'b0);
		send_word(KIND_START, 3, 1'b1);
		send_word(KIND_STOP, 3, 1'b0);
		send_word(KIND_SET_EN, 3, 1'b1);
		send_word(KIND_STOP, 2, 1'b0);
		send_word(KIND_STOP_ALL, 0, 1'b0);
		send_word(KIND_FREE, 0, 1'b1);
		send_word(KIND_FREE, 1, 1'b0);
		send_word(KIND_START, MAX_SLOTS + 1, 1'b1);
		send_word(KIND_STOP, 127, 1'b1);
		send_word(KIND_SET_EN, 64, 1'b0);
		send_word(KIND_START, MAX_SLOTS, 1'b1);
		send_word(KIND_FREE, MAX_SLOTS, 1'b0);
		send_word(KIND_FREE, 3, 1'b0);
		send_word(KIND_ALLOC, 0, 1'b0);
		send_word(KIND_FREE_ALL, 0, 1'b0);
		send_word(KIND_ALLOC, 0, 1'b0);
		send_word(KIND_STOP_ALL, 127, 1'b1);
		pause_until_drained();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_plan[ph];
			stall_pct = stall_plan[ph];
			if (ph == 2)
				hold_off_request = 1'b1;
			target = words_sent + RANDOM_WORDS / 4;
			while (words_sent < target)
				run_random_episode();
			pause_until_drained();
		end

		idle_pct  = 0;
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (replies.errors == 0 && replies.expected_replies.size() == 0)
			$display("PASS effect_slot_allocator_core");
		else
			$display("FAIL effect_slot_allocator_core");
		$finish;
	end

endmodule
